/* rtl/core/gradient_noise_octave_sum_unit_assert.svh */
// ---------------------------------------------------------------------------
// gradient noise octave sum assertion macros
// immediate-free concurrent checks, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_OCTAVE_SUM_UNIT_ASSERT_SVH
`define GRADIENT_NOISE_OCTAVE_SUM_UNIT_ASSERT_SVH

`ifndef SYNTH
`define GNOS_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gnos assertion failed");
`define GNOS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gnos assertion failed");
`else
`define GNOS_ASSERT(lbl, ante, cons)
`define GNOS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/gnos_pkg.sv */
// ---------------------------------------------------------------------------
// gnos_pkg
// shared constants and types of the gradient noise octave sum unit
// ---------------------------------------------------------------------------
package gnos_pkg;

  localparam int DEF_TABLE_SIZE  = 256;
  localparam int DEF_MAX_OCTAVES = 8;

  localparam int FRAC_W      = 16;
  localparam int FADE_W      = 17;
  localparam int FREQ_W      = 48;
  localparam int FREQ_FRAC_W = 12;
  localparam int AMP_W       = 17;
  localparam int QUOT_W      = 16;
  localparam int OUT_W       = 16;
  localparam int PERM_W      = 8;
  localparam int COORD_W     = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [FREQ_W-1:0] FREQ_ONE = FREQ_W'(4096);
  localparam logic [FREQ_W-1:0] FREQ_CAP = FREQ_W'(1) << 47;
  localparam logic [AMP_W-1:0]  AMP_ONE  = AMP_W'(65536);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSIST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LACUN   = 2'd2;

  typedef logic [FRAC_W-1:0] frac_t;
  typedef logic [FADE_W-1:0] fade_t;

endpackage

/* rtl/core/gnos_fade.sv */
// ---------------------------------------------------------------------------
// gnos_fade
// three stage quintic fade curve 6t^5 - 15t^4 + 10t^3 in q16
// ---------------------------------------------------------------------------
module gnos_fade (
  input  logic          clk,
  input  gnos_pkg::frac_t f,
  output gnos_pkg::fade_t fade
);
  import gnos_pkg::*;

  logic [2*FRAC_W-1:0] ff_r;
  frac_t               f1_r;
  logic [2*FRAC_W-1:0] t3a_r;
  logic [19:0]         inner_r;
  fade_t               fade_r;
  logic [35:0]         inner_full;
  logic [35:0]         fprod;

  assign inner_full = 36'(ff_r) * 36'd6 + (36'd10 << 32) - ((36'(f1_r) * 36'd15) << 16);
  assign fprod      = 36'(t3a_r[2*FRAC_W-1:FRAC_W]) * 36'(inner_r);

  always_ff @(posedge clk) begin
    ff_r    <= 32'(f) * 32'(f);
    f1_r    <= f;
    t3a_r   <= 32'(ff_r[2*FRAC_W-1:FRAC_W]) * 32'(f1_r);
    inner_r <= inner_full[35:16];
    fade_r  <= fprod[FADE_W+15:16];
  end

  assign fade = fade_r;

endmodule

/* rtl/core/gnos_div.sv */
// ---------------------------------------------------------------------------
// gnos_div
// signed by unsigned restoring divider, one quotient bit per cycle, saturated
// ---------------------------------------------------------------------------
module gnos_div #(
  parameter int TW  = 40,
  parameter int DVW = 23
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [TW-1:0]          dividend,
  input  logic [DVW-1:0]                divisor,
  output logic                          done,
  output logic signed [gnos_pkg::OUT_W-1:0] quotient
);
  import gnos_pkg::*;

  localparam int CW    = (TW > DVW + QUOT_W) ? TW : DVW + QUOT_W;
  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [CW-1:0]     rem_r;
  logic [CW-1:0]     dsh_r;
  logic [QUOT_W-1:0] q_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              neg_r;
  logic              busy_r;
  logic              done_r;
  logic [TW-1:0]     mag;
  logic              ge;
  logic signed [QUOT_W:0] qs;

  assign mag = dividend[TW-1] ? TW'(-dividend) : TW'(dividend);
  assign ge  = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= CW'(mag);
      dsh_r <= CW'(divisor) << (QUOT_W - 1);
      q_r   <= '0;
      neg_r <= dividend[TW-1];
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= {q_r[QUOT_W-2:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  always_comb begin
    qs = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    if (qs > (QUOT_W+1)'(32767)) begin
      quotient = OUT_W'(32767);
    end else if (qs < -(QUOT_W+1)'(32768)) begin
      quotient = OUT_W'(-32768);
    end else begin
      quotient = OUT_W'(qs);
    end
  end

  assign done = done_r;

endmodule

/* rtl/core/gradient_noise_octave_sum_unit.sv */
// ---------------------------------------------------------------------------
// gradient_noise_octave_sum_unit
// fractal sum of 2-d gradient noise over a programmable number of octaves
// ---------------------------------------------------------------------------
// input channel: in_valid / in_stall, one request per accepted edge. a load
//   request (operation 0) writes one permutation entry and returns nothing; an
//   evaluate request (operation 1) returns one out_noise_value on the
//   out_valid / out_stall channel.
// in_stall is high while an evaluation is in progress; the block works on
//   one request at a time. each octave is paced by the three dependent reads
//   of the two permutation memory copies and the fade, lerp and amplitude
//   multiply chain; the final division runs on the bit-serial divider.
// the result waits in the output register while out_stall is high; new
//   requests are accepted meanwhile, and a finished evaluation holds until
//   the output register is free.
// the configuration port may be written whenever the block is idle.
// reset (rst_n low, synchronous) clears the control state and loads the
//   register defaults; the permutation table is not cleared and must be
//   loaded before it is read.
// ---------------------------------------------------------------------------
module gradient_noise_octave_sum_unit #(
  parameter int TABLE_SIZE  = gnos_pkg::DEF_TABLE_SIZE,
  parameter int MAX_OCTAVES = gnos_pkg::DEF_MAX_OCTAVES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [gnos_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gnos_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_operation,
  input  logic [7:0]                          in_entry_index,
  input  logic [7:0]                          in_entry_value,
  input  logic signed [gnos_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [gnos_pkg::COORD_W-1:0] in_coord_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [gnos_pkg::OUT_W-1:0]   out_noise_value
);
  import gnos_pkg::*;

`include "gradient_noise_octave_sum_unit_assert.svh"

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int NB    = FREQ_FRAC_W + FRAC_W + IDX_W;
  localparam int HB    = NB / 2;
  localparam int HI_W  = NB - HB;
  localparam int SW    = FRAC_W + IDX_W;
  localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
  localparam int ASW   = AMP_W + $clog2(MAX_OCTAVES);
  localparam int GW    = FRAC_W + 3;
  localparam int DW    = GW + 1;
  localparam int LPW   = DW + FADE_W + 1;
  localparam int PAW   = GW + AMP_W;
  localparam int TW    = PAW + $clog2(MAX_OCTAVES) + 1;
  localparam int DVW   = ASW + 3;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_SUM    = 4'd2;
  localparam logic [3:0] S_RD1    = 4'd3;
  localparam logic [3:0] S_RD2    = 4'd4;
  localparam logic [3:0] S_RD3    = 4'd5;
  localparam logic [3:0] S_GRAD   = 4'd6;
  localparam logic [3:0] S_L1     = 4'd7;
  localparam logic [3:0] S_L2     = 4'd8;
  localparam logic [3:0] S_L3     = 4'd9;
  localparam logic [3:0] S_L4     = 4'd10;
  localparam logic [3:0] S_ACC    = 4'd11;
  localparam logic [3:0] S_ACC2   = 4'd12;
  localparam logic [3:0] S_DSTART = 4'd13;
  localparam logic [3:0] S_DIV    = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  function automatic logic signed [GW-1:0] grad(input logic [1:0] h,
                                                input logic signed [FRAC_W+1:0] dx,
                                                input logic signed [FRAC_W+1:0] dy);
    logic signed [GW-1:0] u;
    logic signed [GW-1:0] v;
    u    = h[1] ? GW'(dy) : GW'(dx);
    v    = h[1] ? GW'(dx) : GW'(dy);
    grad = (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  // configuration
  logic [3:0]  oct_cfg_r;
  logic [15:0] pers_r;
  logic [15:0] lac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_cfg_r <= 4'd1;
      pers_r    <= 16'd32768;
      lac_r     <= 16'd8192;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_OCTAVES: oct_cfg_r <= cfg_wdata[3:0];
        CFG_PERSIST: pers_r    <= cfg_wdata;
        CFG_LACUN:   lac_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control
  logic [3:0]       state_r;
  logic [3:0]       state_nxt;
  logic [OCT_W-1:0] oct_r;
  logic [OCT_W-1:0] n_r;
  logic [OCT_W-1:0] n_start;
  logic             in_acc;
  logic             out_load;
  logic             out_valid_r;
  logic signed [OUT_W-1:0] out_val_r;

  // datapath
  logic [COORD_W-1:0]  x_r;
  logic [COORD_W-1:0]  y_r;
  logic [FREQ_W-1:0]   freq_r;
  logic [AMP_W-1:0]    amp_r;
  logic [ASW-1:0]      asum_r;
  logic signed [TW-1:0] total_r;
  logic [NB-1:0]       pxl_r;
  logic [NB-1:0]       pyl_r;
  logic [HI_W-1:0]     pxh_r;
  logic [HI_W-1:0]     pyh_r;
  logic [SW-1:0]       sx_r;
  logic [SW-1:0]       sy_r;
  logic [IDX_W-1:0]    a_r;
  logic [IDX_W-1:0]    b_r;
  logic [1:0]          h00_r;
  logic [1:0]          h10_r;
  logic signed [GW-1:0] n00_r;
  logic signed [GW-1:0] n10_r;
  logic signed [GW-1:0] n01_r;
  logic signed [GW-1:0] n11_r;
  logic signed [LPW-1:0] p1_r;
  logic signed [LPW-1:0] p2_r;
  logic signed [LPW-1:0] p3_r;
  logic signed [GW-1:0] ab_r;
  logic signed [GW-1:0] cd_r;
  logic signed [GW-1:0] nz_r;
  logic signed [PAW-1:0] pa_r;

  logic [NB-1:0]       xe;
  logic [NB-1:0]       ye;
  logic [NB-1:0]       sxf;
  logic [NB-1:0]       syf;
  frac_t               fx;
  frac_t               fy;
  logic [IDX_W-1:0]    cx;
  logic [IDX_W-1:0]    cy;
  fade_t               fu;
  fade_t               fv;
  logic signed [FRAC_W+1:0] dx0;
  logic signed [FRAC_W+1:0] dy0;
  logic signed [FRAC_W+1:0] dx1;
  logic signed [FRAC_W+1:0] dy1;
  logic signed [DW-1:0] d1;
  logic signed [DW-1:0] d2;
  logic signed [DW-1:0] d3;
  logic [AMP_W+15:0]   amp_prod;
  logic [FREQ_W+15:0]  freq_prod;
  logic [FREQ_W+3:0]   freq_sh;
  logic [FREQ_W-1:0]   freq_nxt;

  // permutation memory, two copies for two reads a cycle
  logic [PERM_W-1:0] mem0 [TABLE_SIZE];
  logic [PERM_W-1:0] mem1 [TABLE_SIZE];
  logic [PERM_W-1:0] rd0_r;
  logic [PERM_W-1:0] rd1_r;
  logic [IDX_W-1:0]  ra0;
  logic [IDX_W-1:0]  ra1;
  logic              mem_we;
  logic [IDX_W-1:0]  wa;

  logic                    div_start;
  logic                    div_done;
  logic signed [OUT_W-1:0] div_quot;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign mem_we   = in_acc && (in_operation == OP_LOAD);
  assign wa       = IDX_W'(in_entry_index);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem0[wa] <= in_entry_value;
    end
    rd0_r <= mem0[ra0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem1[wa] <= in_entry_value;
    end
    rd1_r <= mem1[ra1];
  end

  always_comb begin
    if (oct_cfg_r == 4'd0) begin
      n_start = OCT_W'(1);
    end else if (32'(oct_cfg_r) > MAX_OCTAVES) begin
      n_start = OCT_W'(MAX_OCTAVES);
    end else begin
      n_start = OCT_W'(oct_cfg_r);
    end
  end

  assign xe  = NB'($signed(x_r));
  assign ye  = NB'($signed(y_r));
  assign sxf = pxl_r + {pxh_r, {HB{1'b0}}};
  assign syf = pyl_r + {pyh_r, {HB{1'b0}}};
  assign fx  = sx_r[FRAC_W-1:0];
  assign fy  = sy_r[FRAC_W-1:0];
  assign cx  = sx_r[SW-1:FRAC_W];
  assign cy  = sy_r[SW-1:FRAC_W];

  assign dx0 = $signed({2'b00, fx});
  assign dy0 = $signed({2'b00, fy});
  assign dx1 = dx0 - $signed(18'h10000);
  assign dy1 = dy0 - $signed(18'h10000);

  assign d1 = DW'(n10_r) - DW'(n00_r);
  assign d2 = DW'(n11_r) - DW'(n01_r);
  assign d3 = DW'(cd_r) - DW'(ab_r);

  assign amp_prod  = (AMP_W+16)'(amp_r) * (AMP_W+16)'(pers_r);
  assign freq_prod = (FREQ_W+16)'(freq_r) * (FREQ_W+16)'(lac_r);
  assign freq_sh   = freq_prod[FREQ_W+15:FREQ_FRAC_W];
  assign freq_nxt  = (freq_sh > (FREQ_W+4)'(FREQ_CAP)) ? FREQ_CAP : freq_sh[FREQ_W-1:0];

  gnos_fade u_fade_x (
    .clk  (clk),
    .f    (fx),
    .fade (fu)
  );

  gnos_fade u_fade_y (
    .clk  (clk),
    .f    (fy),
    .fade (fv)
  );

  always_comb begin
    case (state_r)
      S_RD2: begin
        ra0 = IDX_W'(rd0_r) + cy;
        ra1 = IDX_W'(rd1_r) + cy;
      end
      S_RD3: begin
        ra0 = a_r + IDX_W'(1);
        ra1 = b_r + IDX_W'(1);
      end
      default: begin
        ra0 = cx;
        ra1 = cx + IDX_W'(1);
      end
    endcase
  end

  assign div_start = (state_r == S_DSTART);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_operation == OP_EVAL)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_RD1;
      S_RD1:  state_nxt = S_RD2;
      S_RD2:  state_nxt = S_RD3;
      S_RD3:  state_nxt = S_GRAD;
      S_GRAD: state_nxt = S_L1;
      S_L1:   state_nxt = S_L2;
      S_L2:   state_nxt = S_L3;
      S_L3:   state_nxt = S_L4;
      S_L4:   state_nxt = S_ACC;
      S_ACC:  state_nxt = S_ACC2;
      S_ACC2: begin
        state_nxt = ((oct_r + OCT_W'(1)) == n_r) ? S_DSTART : S_MUL;
      end
      S_DSTART: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oct_r       <= '0;
      out_valid_r <= 1'b0;
      freq_r      <= FREQ_ONE;
      amp_r       <= AMP_ONE;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc && (in_operation == OP_EVAL)) begin
        oct_r  <= '0;
        freq_r <= FREQ_ONE;
        amp_r  <= AMP_ONE;
      end else if (state_r == S_ACC2) begin
        oct_r  <= oct_r + OCT_W'(1);
        freq_r <= freq_nxt;
        amp_r  <= amp_prod[AMP_W+15:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_operation == OP_EVAL)) begin
      x_r     <= in_coord_x;
      y_r     <= in_coord_y;
      n_r     <= n_start;
      asum_r  <= '0;
      total_r <= '0;
    end
    if (state_r == S_MUL) begin
      pxl_r <= xe * NB'(freq_r[HB-1:0]);
      pyl_r <= ye * NB'(freq_r[HB-1:0]);
      pxh_r <= xe[HI_W-1:0] * freq_r[NB-1:HB];
      pyh_r <= ye[HI_W-1:0] * freq_r[NB-1:HB];
    end
    if (state_r == S_SUM) begin
      sx_r <= sxf[NB-1:FREQ_FRAC_W];
      sy_r <= syf[NB-1:FREQ_FRAC_W];
    end
    if (state_r == S_RD2) begin
      a_r <= ra0;
      b_r <= ra1;
    end
    if (state_r == S_RD3) begin
      h00_r <= rd0_r[1:0];
      h10_r <= rd1_r[1:0];
    end
    if (state_r == S_GRAD) begin
      n00_r <= grad(h00_r, dx0, dy0);
      n10_r <= grad(h10_r, dx1, dy0);
      n01_r <= grad(rd0_r[1:0], dx0, dy1);
      n11_r <= grad(rd1_r[1:0], dx1, dy1);
    end
    if (state_r == S_L1) begin
      p1_r <= LPW'(d1) * LPW'($signed({1'b0, fu}));
      p2_r <= LPW'(d2) * LPW'($signed({1'b0, fu}));
    end
    if (state_r == S_L2) begin
      ab_r <= n00_r + $signed(p1_r[FRAC_W+GW-1:FRAC_W]);
      cd_r <= n01_r + $signed(p2_r[FRAC_W+GW-1:FRAC_W]);
    end
    if (state_r == S_L3) begin
      p3_r <= LPW'(d3) * LPW'($signed({1'b0, fv}));
    end
    if (state_r == S_L4) begin
      nz_r <= ab_r + $signed(p3_r[FRAC_W+GW-1:FRAC_W]);
    end
    if (state_r == S_ACC) begin
      pa_r <= PAW'(nz_r) * PAW'($signed({1'b0, amp_r}));
    end
    if (state_r == S_ACC2) begin
      total_r <= total_r + TW'(pa_r);
      asum_r  <= asum_r + ASW'(amp_r);
    end
    if (out_load) begin
      out_val_r <= div_quot;
    end
  end

  gnos_div #(
    .TW  (TW),
    .DVW (DVW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total_r),
    .divisor  ({asum_r, 3'b000}),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_val_r;

  `GNOS_ASSERT(a_oct_range, state_r != S_IDLE, oct_r <= n_r)
  `GNOS_ASSERT(a_freq_cap, 1'b1, freq_r <= FREQ_CAP)
  `GNOS_ASSERT(a_div_done_wait, div_done, state_r == S_DIV)
  `GNOS_ASSERT_NXT(a_out_load, out_load, out_valid_r && (state_r == S_IDLE))

endmodule
